// ----- rtl/core/lddt_window_score_defines.svh -----
// Assertion macros shared by the lDDT window score RTL.
// Included by lddt_window_score, which carries the concurrent checks; no other dependencies.
`ifndef LDDT_WINDOW_SCORE_DEFINES_SVH
`define LDDT_WINDOW_SCORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define LDDT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lddt check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define LDDT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lddt check failed: next-cycle implication");

`endif

// ----- rtl/core/lddt_pkg.sv -----
// Shared constants, types and register indexes for the lDDT window score block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lddt_pkg;

    localparam int DIST_W     = 16;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = DIST_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

    localparam int NUM_TOL    = 4;
    localparam int MAX_PAIRS  = 4095;
    localparam int TALLY_W    = 12;
    localparam int PRES_W     = 14;
    localparam int MET_W      = $clog2(NUM_TOL + 1);

    localparam int SCORE_W    = 16;
    localparam int QUO_W      = SCORE_W + 1;
    localparam int QUO_CNT_W  = $clog2(QUO_W);
    localparam int DEN_W      = $clog2(NUM_TOL * MAX_PAIRS + 1);

    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_C  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_D  = 3'd4;

    typedef logic [NUM_TOL-1:0][DIST_W-1:0] tol_arr_t;

    // Result of one serial pair evaluation
    typedef struct packed {
        logic             valid;
        logic             in_radius;
        logic [MET_W-1:0] met;
    } eval_res_t;

    // Result of one window division
    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [TALLY_W-1:0] tally;
    } div_res_t;

endpackage

// ----- rtl/core/lddt_pair_eval.sv -----
// Digit-serial pair evaluator: absolute distance difference against the
// tolerances and query distance against the radius, one digit per cycle.
// Depends on lddt_pkg.
`timescale 1ns / 1ps

module lddt_pair_eval
    import lddt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIST_W-1:0] dist_query,
    input  logic [DIST_W-1:0] dist_other,
    input  logic [DIST_W-1:0] radius,
    input  tol_arr_t          tol,
    output eval_res_t         res
);

    logic                 busy_reg, busy_next;
    logic [DIG_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIST_W-1:0]    dq_sr_reg, dq_sr_next;
    logic [DIST_W-1:0]    doth_sr_reg, doth_sr_next;
    logic [DIST_W-1:0]    rad_sr_reg, rad_sr_next;
    tol_arr_t             tol_sr_reg, tol_sr_next;
    logic                 b1_reg, b1_next;
    logic                 b2_reg, b2_next;
    logic                 le_rad_reg, le_rad_next;
    logic [NUM_TOL-1:0]   le1_reg, le1_next;
    logic [NUM_TOL-1:0]   le2_reg, le2_next;
    eval_res_t            res_reg, res_next;

    logic [DIGIT_W-1:0]   dq_d, doth_d, rad_d, dig1, dig2;
    logic [DIGIT_W:0]     s1, s2;
    logic                 last_digit;
    logic [MET_W-1:0]     met_cnt;

    // LSB-first "a <= b" update for one digit
    function automatic logic digit_le(input logic [DIGIT_W-1:0] a,
                                      input logic [DIGIT_W-1:0] b,
                                      input logic prev);
        logic r;
        if (a < b) begin
            r = 1'b1;
        end else if (a > b) begin
            r = 1'b0;
        end else begin
            r = prev;
        end
        return r;
    endfunction

    assign dq_d   = dq_sr_reg[DIGIT_W-1:0];
    assign doth_d = doth_sr_reg[DIGIT_W-1:0];
    assign rad_d  = rad_sr_reg[DIGIT_W-1:0];

    // Both subtraction directions, one digit with borrow
    assign s1   = {1'b0, dq_d} - {1'b0, doth_d} - {{DIGIT_W{1'b0}}, b1_reg};
    assign s2   = {1'b0, doth_d} - {1'b0, dq_d} - {{DIGIT_W{1'b0}}, b2_reg};
    assign dig1 = s1[DIGIT_W-1:0];
    assign dig2 = s2[DIGIT_W-1:0];

    assign last_digit = (cnt_reg == DIG_CNT_W'(NUM_DIGITS - 1));

    always_comb begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        dq_sr_next   = dq_sr_reg;
        doth_sr_next = doth_sr_reg;
        rad_sr_next  = rad_sr_reg;
        tol_sr_next  = tol_sr_reg;
        b1_next      = b1_reg;
        b2_next      = b2_reg;
        le_rad_next  = le_rad_reg;
        le1_next     = le1_reg;
        le2_next     = le2_reg;
        res_next     = res_reg;
        res_next.valid = 1'b0;
        met_cnt      = '0;

        if (start) begin
            // load operands, comparisons start as "equal so far"
            busy_next    = 1'b1;
            cnt_next     = '0;
            dq_sr_next   = dist_query;
            doth_sr_next = dist_other;
            rad_sr_next  = radius;
            tol_sr_next  = tol;
            b1_next      = 1'b0;
            b2_next      = 1'b0;
            le_rad_next  = 1'b1;
            le1_next     = '1;
            le2_next     = '1;
        end else if (busy_reg) begin
            // advance one digit
            b1_next     = s1[DIGIT_W];
            b2_next     = s2[DIGIT_W];
            le_rad_next = digit_le(dq_d, rad_d, le_rad_reg);
            for (int k = 0; k < NUM_TOL; k++) begin
                le1_next[k] = digit_le(dig1, tol_sr_reg[k][DIGIT_W-1:0], le1_reg[k]);
                le2_next[k] = digit_le(dig2, tol_sr_reg[k][DIGIT_W-1:0], le2_reg[k]);
                tol_sr_next[k] = tol_sr_reg[k] >> DIGIT_W;
            end
            dq_sr_next   = dq_sr_reg >> DIGIT_W;
            doth_sr_next = doth_sr_reg >> DIGIT_W;
            rad_sr_next  = rad_sr_reg >> DIGIT_W;
            cnt_next     = cnt_reg + 1'b1;

            if (last_digit) begin
                // final borrow of query minus other picks the difference direction
                for (int k = 0; k < NUM_TOL; k++) begin
                    met_cnt = met_cnt + MET_W'(s1[DIGIT_W] ? le2_next[k] : le1_next[k]);
                end
                busy_next          = 1'b0;
                res_next.valid     = 1'b1;
                res_next.in_radius = le_rad_next;
                res_next.met       = met_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            res_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_sr_reg   <= dq_sr_next;
        doth_sr_reg <= doth_sr_next;
        rad_sr_reg  <= rad_sr_next;
        tol_sr_reg  <= tol_sr_next;
        b1_reg      <= b1_next;
        b2_reg      <= b2_next;
        le_rad_reg  <= le_rad_next;
        le1_reg     <= le1_next;
        le2_reg     <= le2_next;
    end

    assign res = res_reg;

endmodule

// ----- rtl/core/lddt_div.sv -----
// Bit-serial restoring divider: preserved sum * 2^16 / (NUM_TOL * tally),
// one quotient bit per cycle, saturated to the score width.
// Depends on lddt_pkg.
`timescale 1ns / 1ps

module lddt_div
    import lddt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [PRES_W-1:0]  pres,
    input  logic [TALLY_W-1:0] tally,
    output div_res_t           res
);

    logic                 busy_reg, busy_next;
    logic                 valid_reg, valid_next;
    logic [QUO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [QUO_W-1:0]     dsr_reg, dsr_next;
    logic [QUO_W-1:0]     q_reg, q_next;
    logic [TALLY_W-1:0]   tally_reg, tally_next;

    logic [DEN_W:0]       r_sh;
    logic                 ge;

    // Shift in the next dividend bit and trial-subtract
    assign r_sh = {rem_reg, dsr_reg[QUO_W-1]};
    assign ge   = (r_sh >= {1'b0, den_reg});

    always_comb begin
        busy_next  = busy_reg;
        valid_next = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        dsr_next   = dsr_reg;
        q_next     = q_reg;
        tally_next = tally_reg;

        if (start) begin
            tally_next = tally;
            den_next   = DEN_W'(tally) * DEN_W'(NUM_TOL);
            // top bits of the dividend already sit below the divisor
            rem_next   = DEN_W'(pres >> 1);
            dsr_next   = {pres[0], {(QUO_W-1){1'b0}}};
            q_next     = '0;
            cnt_next   = '0;
            if (tally == '0) begin
                valid_next = 1'b1;
            end else begin
                busy_next  = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = ge ? DEN_W'(r_sh - {1'b0, den_reg}) : DEN_W'(r_sh);
            q_next   = {q_reg[QUO_W-2:0], ge};
            dsr_next = dsr_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == QUO_CNT_W'(QUO_W - 1)) begin
                busy_next  = 1'b0;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        dsr_reg   <= dsr_next;
        q_reg     <= q_next;
        tally_reg <= tally_next;
    end

    // Saturate a full score of one
    assign res.valid = valid_reg;
    assign res.score = q_reg[QUO_W-1] ? {SCORE_W{1'b1}} : q_reg[SCORE_W-1:0];
    assign res.tally = tally_reg;

endmodule

// ----- rtl/core/lddt_window_score.sv -----
// lddt_window_score: windowed lDDT score over a stream of residue-pair distances.
// Input stream (s_*): one pair per transfer; tdata holds dist_query and dist_other,
// tuser the two presence flags, tlast marks the last pair of a window.
// Output stream (m_*): one transfer per window, window_score (Q0.16) and pairs_seen.
// Config channel (cfg_*): register index and 16-bit data, always ready; write only
// while the block is idle.
// Each pair is evaluated digit-serially, 4 bits per cycle over 4 digits. The operands
// are loaded, the digits evaluated and the sums folded before the next pair is taken.
// A last pair adds a divider load, a bit-serial division of 17 quotient bits and a
// hand-off through ST_OUT; m_tvalid rises with the result in the output register,
// and s_tready returns in the same cycle.
// The output register lets the next window's pairs be accepted while a result
// waits; if the receiver still stalls when the following window's result is ready,
// that result stays in the divider and s_tready stays low until the register frees.
// Reset (aresetn low, synchronous) clears the sums, drops any pending result and
// restores the registers: radius 3840, tolerances 128, 256, 512, 1024.
// Pairs beyond 4095 in one window are ignored; a window score of one saturates
// to 65535.
`timescale 1ns / 1ps
`include "lddt_window_score_defines.svh"

module lddt_window_score
    import lddt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input pairs
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [15:0] dist_query, [31:16] dist_other
    input  logic [1:0]           s_tuser,   // [0] query_present, [1] other_present
    input  logic                 s_tlast,   // last_pair
    // window results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [15:0] window_score, [27:16] pairs_seen, [31:28] zero
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]    cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DIST_W-1:0]  radius_reg;
    tol_arr_t           tol_reg;
    logic [PRES_W-1:0]  pres_reg, pres_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic               both_reg, last_reg, counts_reg;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_data_reg, m_data_next;

    logic               s_xfer, cfg_xfer;
    eval_res_t          eval_res;
    div_res_t           div_res;
    logic               div_start;
    logic [TALLY_W-1:0] tally_upd;
    logic [PRES_W-1:0]  pres_upd;
    logic [PRES_W:0]    pres_sum;
    logic [MET_W-1:0]   pres_add;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 16'd3840;
            tol_reg[0] <= 16'd128;
            tol_reg[1] <= 16'd256;
            tol_reg[2] <= 16'd512;
            tol_reg[3] <= 16'd1024;
        end else if (cfg_xfer) begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_TOL_A:  tol_reg[0] <= cfg_data;
                CFG_TOL_B:  tol_reg[1] <= cfg_data;
                CFG_TOL_C:  tol_reg[2] <= cfg_data;
                CFG_TOL_D:  tol_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    lddt_pair_eval u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_xfer),
        .dist_query (s_tdata[15:0]),
        .dist_other (s_tdata[31:16]),
        .radius     (radius_reg),
        .tol        (tol_reg),
        .res        (eval_res)
    );

    // Fold the evaluated pair into the window sums
    assign pres_add  = (counts_reg && both_reg && eval_res.in_radius) ? eval_res.met : '0;
    assign pres_sum  = {1'b0, pres_reg} + (PRES_W + 1)'(pres_add);
    assign pres_upd  = pres_sum[PRES_W] ? {PRES_W{1'b1}} : pres_sum[PRES_W-1:0];
    assign tally_upd = counts_reg ? (tally_reg + 1'b1) : tally_reg;
    assign div_start = (state_reg == ST_EVAL) && eval_res.valid && last_reg;

    lddt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pres    (pres_upd),
        .tally   (tally_upd),
        .res     (div_res)
    );

    always_comb begin
        state_next   = state_reg;
        pres_next    = pres_reg;
        tally_next   = tally_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // drop the result once the receiver takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (eval_res.valid) begin
                    if (last_reg) begin
                        // divider holds its own copy; clear the window
                        pres_next  = '0;
                        tally_next = '0;
                        state_next = ST_DIV;
                    end else begin
                        pres_next  = pres_upd;
                        tally_next = tally_upd;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (div_res.valid) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, div_res.tally, div_res.score};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pres_reg    <= '0;
            tally_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pres_reg    <= pres_next;
            tally_reg   <= tally_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the accepted pair's flags and the output payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            both_reg   <= s_tuser[0] && s_tuser[1];
            last_reg   <= s_tlast;
            counts_reg <= (tally_reg < TALLY_W'(MAX_PAIRS));
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `LDDT_ASSERT_NEXT(a_accept_starts_eval, aclk, aresetn, s_xfer, state_reg == ST_EVAL)
    `LDDT_ASSERT_IMP(a_eval_res_in_eval, aclk, aresetn, eval_res.valid, state_reg == ST_EVAL)
    `LDDT_ASSERT_IMP(a_div_res_in_div, aclk, aresetn, div_res.valid, state_reg == ST_DIV)
    `LDDT_ASSERT_IMP(a_tally_bound, aclk, aresetn, 1'b1, tally_reg <= TALLY_W'(MAX_PAIRS))
    `LDDT_ASSERT_IMP(a_pres_bound, aclk, aresetn, 1'b1,
        (PRES_W + 2)'(pres_reg) <= (PRES_W + 2)'(tally_reg) * (PRES_W + 2)'(NUM_TOL))

endmodule

// ----- dv/lddt_score_checker.sv -----
// Scoreboard for the lDDT window score block: watches the pair, result and config channels.
// Predicts each window result from the accepted pairs and compares it field by field.
// Depends on lddt_pkg for widths, register indexes and the tolerance array type.
`timescale 1ns / 1ps

module lddt_score_checker
    import lddt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [15:0] dist_query, [31:16] dist_other
    input  logic [1:0]           s_tuser,   // [0] query_present, [1] other_present
    input  logic                 s_tlast,   // last_pair
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,   // [15:0] window_score, [27:16] pairs_seen
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   windows_pending
);

    localparam logic [DIST_W-1:0] RADIUS_AT_RESET = 16'd3840;
    localparam logic [DIST_W-1:0] TOL_A_AT_RESET  = 16'd128;
    localparam logic [DIST_W-1:0] TOL_B_AT_RESET  = 16'd256;
    localparam logic [DIST_W-1:0] TOL_C_AT_RESET  = 16'd512;
    localparam logic [DIST_W-1:0] TOL_D_AT_RESET  = 16'd1024;
    localparam int unsigned       PRESERVED_CAP   = (1 << PRES_W) - 1;
    localparam longint unsigned   SCORE_CAP       = (1 << SCORE_W) - 1;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TALLY_W-1:0] tally;
    } window_result_t;

    logic [DIST_W-1:0] radius;
    tol_arr_t          tol;
    logic [PRES_W-1:0] preserved;
    logic [TALLY_W-1:0] tally;
    window_result_t    expected_windows[$];
    int                fails   = 0;
    int                pending = 0;

    assign fail_count      = fails;
    assign windows_pending = pending;

    always @(posedge aclk) begin
        window_result_t    want;
        logic [DIST_W-1:0] dq;
        logic [DIST_W-1:0] dother;
        logic [DIST_W-1:0] diff;
        int unsigned       held;
        int unsigned       sum;
        longint unsigned   quotient;
        int                k;
        if (!aresetn) begin
            radius    = RADIUS_AT_RESET;
            tol[0]    = TOL_A_AT_RESET;
            tol[1]    = TOL_B_AT_RESET;
            tol[2]    = TOL_C_AT_RESET;
            tol[3]    = TOL_D_AT_RESET;
            preserved = '0;
            tally     = '0;
            expected_windows.delete();
        end else begin
            // compare a result transfer against the oldest closed window
            if (m_tvalid && m_tready) begin
                if (expected_windows.size() == 0) begin
                    $error("window result with no window closed: tdata %h", m_tdata);
                    fails++;
                end else begin
                    want = expected_windows.pop_front();
                    if (m_tdata[15:0] !== want.score) begin
                        $error("window_score expected %0d actual %0d", want.score,
                               m_tdata[15:0]);
                        fails++;
                    end
                    if (m_tdata[27:16] !== want.tally) begin
                        $error("pairs_seen expected %0d actual %0d", want.tally,
                               m_tdata[27:16]);
                        fails++;
                    end
                    if (m_tdata[31:28] !== 4'd0) begin
                        $error("tdata padding expected 0 actual %0h", m_tdata[31:28]);
                        fails++;
                    end
                end
            end

            // fold an accepted pair into the window sums
            if (s_tvalid && s_tready) begin
                dq     = s_tdata[15:0];
                dother = s_tdata[31:16];
                // pairs past the window limit add to neither sum, though a last one still closes the window
                if (tally < MAX_PAIRS) begin
                    tally = tally + 1'b1;
                    if (s_tuser[0] && s_tuser[1] && dq <= radius) begin
                        diff = (dq >= dother) ? dq - dother : dother - dq;
                        held = 0;
                        for (k = 0; k < NUM_TOL; k++) begin
                            if (diff <= tol[k])
                                held++;
                        end
                        sum       = preserved + held;
                        preserved = (sum > PRESERVED_CAP) ? PRES_W'(PRESERVED_CAP)
                                                          : PRES_W'(sum);
                    end
                end
                // close the window: average over four tolerances per pair
                if (s_tlast) begin
                    if (tally == 0) begin
                        quotient = 0;
                    end else begin
                        quotient = (longint'(preserved) << SCORE_W)
                                   / (longint'(NUM_TOL) * tally);
                        if (quotient > SCORE_CAP)
                            quotient = SCORE_CAP;
                    end
                    want.score = quotient[SCORE_W-1:0];
                    want.tally = tally;
                    expected_windows.insert(expected_windows.size(), want);
                    preserved = '0;
                    tally     = '0;
                end
            end

            // mirror register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RADIUS: radius = cfg_data;
                    CFG_TOL_A:  tol[0] = cfg_data;
                    CFG_TOL_B:  tol[1] = cfg_data;
                    CFG_TOL_C:  tol[2] = cfg_data;
                    CFG_TOL_D:  tol[3] = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = expected_windows.size();
    end

endmodule

// ----- dv/tb_lddt_window_score.sv -----
// Top of the lDDT window score testbench: clock, reset, pair and config stimulus, verdict.
// Instantiates lddt_window_score and lddt_score_checker; uses lddt_pkg for indexes.
`timescale 1ns / 1ps

module tb_lddt_window_score;
    import lddt_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int ITEMS_PER_SET = 220;
    localparam int HOLD_CYCLES   = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIST_W-1:0]    cfg_data;

    int                   score_fails;
    int                   windows_open;

    // stimulus-side copy of the registers, only used to aim distances
    logic [DIST_W-1:0]    cur_radius;
    logic [DIST_W-1:0]    cur_tol[NUM_TOL];
    logic                 no_idle   = 1'b0;
    logic                 hold_req  = 1'b0;
    logic                 hold_done = 1'b0;
    int                   phase_items;

    lddt_window_score DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lddt_score_checker score_mon (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (score_fails),
        .windows_pending (windows_open)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // end the run if it never drains
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // offer one pair after a random gap and hold it until the transfer
    task automatic send_pair(input logic [DIST_W-1:0] dq, input logic [DIST_W-1:0] dother,
                             input logic qp, input logic op, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {dother, dq};
        s_tuser  = {op, qp};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        phase_items++;
    endtask

    // drop valid, drain every open window, then let the block finish its last pair
    task automatic settle();
        s_tvalid = 1'b0;
        while (windows_open != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_config(input logic [DIST_W-1:0] r, input logic [DIST_W-1:0] a,
                               input logic [DIST_W-1:0] b, input logic [DIST_W-1:0] c,
                               input logic [DIST_W-1:0] d);
        settle();
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_TOL_A, a);
        write_reg(CFG_TOL_B, b);
        write_reg(CFG_TOL_C, c);
        write_reg(CFG_TOL_D, d);
        cur_radius = r;
        cur_tol[0] = a;
        cur_tol[1] = b;
        cur_tol[2] = c;
        cur_tol[3] = d;
        phase_items = 0;
    endtask

    // one window of random length; distances aimed at the radius and tolerance edges
    task automatic random_window();
        int                len;
        logic [DIST_W-1:0] dq;
        logic [DIST_W-1:0] dother;
        logic [DIST_W-1:0] t;
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        no_idle = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
                0:       dq = DIST_W'($urandom_range(0, 65535));
                1:       dq = DIST_W'(cur_radius + $urandom_range(0, 2) - 1);
                2:       dq = DIST_W'($urandom_range(0, cur_radius));
                default: dq = DIST_W'($urandom_range(0, 1023));
            endcase
            t = cur_tol[$urandom_range(0, NUM_TOL - 1)];
            case ($urandom_range(0, 3))
                0:       dother = DIST_W'($urandom_range(0, 65535));
                1:       dother = DIST_W'(dq + t + $urandom_range(0, 1));
                2:       dother = DIST_W'(dq - t - $urandom_range(0, 1));
                default: dother = dq;
            endcase
            send_pair(dq, dother, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                      i == len - 1);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_RADIUS;
        cfg_data    = '0;
        phase_items = 0;
        cur_radius  = 16'd3840;
        cur_tol[0]  = 16'd128;
        cur_tol[1]  = 16'd256;
        cur_tol[2]  = 16'd512;
        cur_tol[3]  = 16'd1024;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed windows at the reset register values
        send_pair(16'd100, 16'd100, 1'b1, 1'b1, 1'b1);          // full score saturates
        send_pair(16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0);           // widest difference
        send_pair(16'hFFFF, 16'd0, 1'b1, 1'b1, 1'b0);           // far outside the radius
        send_pair(16'd200, 16'd200, 1'b0, 1'b1, 1'b0);          // query distance missing
        send_pair(16'd200, 16'd200, 1'b1, 1'b0, 1'b0);          // other distance missing
        send_pair(16'd3840, 16'd3968, 1'b1, 1'b1, 1'b0);        // on radius, on first tolerance
        send_pair(16'd3840, 16'd3969, 1'b1, 1'b1, 1'b1);        // just past first tolerance
        send_pair(16'd3841, 16'd3841, 1'b1, 1'b1, 1'b1);        // just past the radius
        send_pair(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);        // both missing
        send_pair(16'd1000, 16'd2024, 1'b1, 1'b1, 1'b0);        // on last tolerance
        send_pair(16'd2025, 16'd1000, 1'b1, 1'b1, 1'b1);        // just past last tolerance
        send_pair(16'hAAAA, 16'h5555, 1'b1, 1'b1, 1'b0);
        send_pair(16'h5555, 16'hAAAA, 1'b1, 1'b1, 1'b1);

        // all-zero registers: only zero distances with zero difference score
        load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        hold_req = 1'b1;
        while (phase_items < ITEMS_PER_SET) random_window();

        // all-max registers: every present pair scores fully
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        while (phase_items < ITEMS_PER_SET) random_window();

        // descending tolerances
        load_config(DIST_W'($urandom_range(0, 65535)), 16'd1024, 16'd512, 16'd256, 16'd128);
        while (phase_items < ITEMS_PER_SET) random_window();

        // back to the reset values, written explicitly
        load_config(16'd3840, 16'd128, 16'd256, 16'd512, 16'd1024);
        while (phase_items < ITEMS_PER_SET) random_window();

        // two fully random settings
        repeat (2) begin
            load_config(DIST_W'($urandom_range(0, 65535)), DIST_W'($urandom_range(0, 65535)),
                        DIST_W'($urandom_range(0, 65535)), DIST_W'($urandom_range(0, 65535)),
                        DIST_W'($urandom_range(0, 65535)));
            while (phase_items < ITEMS_PER_SET) random_window();
        end

        settle();
        if (score_fails == 0 && windows_open == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
